### design/s5rp_pkg.sv
// Shared types and constants for the SOCKS5 request parser.
package s5rp_pkg;

    localparam logic [7:0] SOCKS_VERSION = 8'd5;
    localparam logic [7:0] ATYP_IPV4     = 8'd1;
    localparam logic [7:0] ATYP_DOMAIN   = 8'd3;
    localparam logic [7:0] ATYP_IPV6     = 8'd4;
    localparam logic [7:0] LEN_IPV4      = 8'd4;
    localparam logic [7:0] LEN_IPV6      = 8'd16;
    localparam logic [8:0] PORT_BYTES    = 9'd2;
    localparam logic [8:0] HDR_BYTES     = 9'd4;
    localparam logic [8:0] HDR_DLEN_BYTES = 9'd5;

    localparam logic       KIND_ADDR = 1'b0;
    localparam logic       KIND_END  = 1'b1;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_INVALID     = 2'd1;
    localparam logic [1:0] STATUS_UNSUPPORTED = 2'd2;

    typedef enum logic [2:0] {
        PH_HDR  = 3'd0,
        PH_DLEN = 3'd1,
        PH_ADDR = 3'd2,
        PH_PHI  = 3'd3,
        PH_PLO  = 3'd4
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [8:0]  byte_count;
        logic        saw_bad_header;
        logic [7:0]  command;
        logic [7:0]  addr_type;
        logic [7:0]  length;
        logic [7:0]  port_high;
        logic        domain_has_nul;
    } state_t;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  address_byte;
        logic [7:0]  address_index;
        logic [1:0]  status;
        logic [7:0]  command;
        logic [7:0]  address_type;
        logic [15:0] port;
        logic [7:0]  address_length;
        logic [8:0]  consumed_count;
    } result_t;

    localparam state_t STATE_FRESH = '{
        phase:          PH_HDR,
        byte_count:     9'd0,
        saw_bad_header: 1'b0,
        command:        8'd0,
        addr_type:      8'd0,
        length:         8'd0,
        port_high:      8'd0,
        domain_has_nul: 1'b0
    };

endpackage

### design/s5rp_step.sv
// Per-byte decode: next parser state and the result caused by one byte.
module s5rp_step import s5rp_pkg::*; (
    input  state_t      state_in,
    input  logic [7:0]  data_byte,
    input  logic        restart,
    output state_t      state_out,
    output logic        result_valid,
    output result_t     result
);

    state_t      cur;
    logic [8:0]  offset;
    logic [8:0]  idx_full;
    logic [7:0]  idx;
    logic [8:0]  idx_plus1;
    logic [15:0] port_full;
    logic [8:0]  consumed_ok;
    logic [8:0]  bc_inc;

    assign cur         = restart ? STATE_FRESH : state_in;
    assign offset      = (cur.addr_type == ATYP_DOMAIN) ? HDR_DLEN_BYTES : HDR_BYTES;
    assign idx_full    = cur.byte_count - offset;
    assign idx         = idx_full[7:0];
    assign idx_plus1   = {1'b0, idx} + 9'd1;
    assign port_full   = {cur.port_high, data_byte};
    assign consumed_ok = offset + {1'b0, cur.length} + PORT_BYTES;
    assign bc_inc      = cur.byte_count + 9'd1;

    // next state
    always_comb begin
        state_out = cur;
        unique case (cur.phase)
            PH_DLEN: begin
                state_out.byte_count = bc_inc;
                if (data_byte == 8'd0) begin
                    state_out = STATE_FRESH;
                end else begin
                    state_out.length = data_byte;
                    state_out.phase  = PH_ADDR;
                end
            end
            PH_ADDR: begin
                state_out.byte_count = bc_inc;
                if (cur.addr_type == ATYP_DOMAIN && data_byte == 8'd0) begin
                    state_out.domain_has_nul = 1'b1;
                end
                if (idx_plus1 >= {1'b0, cur.length}) begin
                    state_out.phase = PH_PHI;
                end
            end
            PH_PHI: begin
                state_out.byte_count = bc_inc;
                state_out.port_high  = data_byte;
                state_out.phase      = PH_PLO;
            end
            PH_PLO: begin
                state_out = STATE_FRESH;
            end
            default: begin
                case (cur.byte_count)
                    9'd0: begin
                        state_out.phase          = PH_HDR;
                        state_out.saw_bad_header = (data_byte != SOCKS_VERSION);
                        state_out.byte_count     = 9'd1;
                    end
                    9'd1: begin
                        state_out.command    = data_byte;
                        state_out.byte_count = 9'd2;
                    end
                    9'd2: begin
                        if (data_byte != 8'd0) begin
                            state_out.saw_bad_header = 1'b1;
                        end
                        state_out.byte_count = 9'd3;
                    end
                    default: begin
                        state_out.addr_type  = data_byte;
                        state_out.byte_count = HDR_BYTES;
                        if (cur.saw_bad_header) begin
                            state_out = STATE_FRESH;
                        end else if (data_byte == ATYP_IPV4) begin
                            state_out.length = LEN_IPV4;
                            state_out.phase  = PH_ADDR;
                        end else if (data_byte == ATYP_IPV6) begin
                            state_out.length = LEN_IPV6;
                            state_out.phase  = PH_ADDR;
                        end else if (data_byte == ATYP_DOMAIN) begin
                            state_out.phase = PH_DLEN;
                        end else begin
                            state_out = STATE_FRESH;
                        end
                    end
                endcase
            end
        endcase
    end

    // result
    always_comb begin
        result_valid = 1'b0;
        result       = '0;
        unique case (cur.phase)
            PH_DLEN: begin
                if (data_byte == 8'd0) begin
                    result_valid        = 1'b1;
                    result.result_kind  = KIND_END;
                    result.status       = STATUS_INVALID;
                    result.command      = cur.command;
                    result.address_type = cur.addr_type;
                end
            end
            PH_ADDR: begin
                result_valid         = 1'b1;
                result.result_kind   = KIND_ADDR;
                result.address_byte  = data_byte;
                result.address_index = idx;
            end
            PH_PHI: begin
                result_valid = 1'b0;
            end
            PH_PLO: begin
                result_valid          = 1'b1;
                result.result_kind    = KIND_END;
                result.command        = cur.command;
                result.address_type   = cur.addr_type;
                result.port           = port_full;
                result.address_length = cur.length;
                if (cur.domain_has_nul || port_full == 16'd0) begin
                    result.status = STATUS_INVALID;
                end else begin
                    result.status         = STATUS_OK;
                    result.consumed_count = consumed_ok;
                end
            end
            default: begin
                if (cur.byte_count != 9'd0 && cur.byte_count != 9'd1
                        && cur.byte_count != 9'd2) begin
                    if (cur.saw_bad_header) begin
                        result_valid        = 1'b1;
                        result.result_kind  = KIND_END;
                        result.status       = STATUS_INVALID;
                        result.command      = cur.command;
                        result.address_type = data_byte;
                    end else if (data_byte != ATYP_IPV4 && data_byte != ATYP_IPV6
                            && data_byte != ATYP_DOMAIN) begin
                        result_valid          = 1'b1;
                        result.result_kind    = KIND_END;
                        result.status         = STATUS_UNSUPPORTED;
                        result.command        = cur.command;
                        result.address_type   = data_byte;
                        result.consumed_count = HDR_BYTES;
                    end
                end
            end
        endcase
    end

endmodule

### design/socks5_request_parser.sv
// Top level of the SOCKS5 request parser: handshakes, state and result registers.
// A result appears on the m_ side in the cycle after its byte is accepted.
// Throughput: one byte per cycle; s_ready drops only while a held result is stalled.
// The result register decouples the sides, so a byte is taken while a result is taken.
// Reset (aresetn low, synchronous): parser returns to the first header byte,
// the result register is emptied.
module socks5_request_parser import s5rp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_restart,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_result_kind,
    output logic [7:0]  m_address_byte,
    output logic [7:0]  m_address_index,
    output logic [1:0]  m_status,
    output logic [7:0]  m_command,
    output logic [7:0]  m_address_type,
    output logic [15:0] m_port,
    output logic [7:0]  m_address_length,
    output logic [8:0]  m_consumed_count
);

    state_t  state_reg;
    state_t  state_next;
    logic    res_valid;
    result_t res;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_reg;
    logic    accept;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    s5rp_step u_step (
        .state_in     (state_reg),
        .data_byte    (s_data_byte),
        .restart      (s_restart),
        .state_out    (state_next),
        .result_valid (res_valid),
        .result       (res)
    );

    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        if (accept) begin
            out_valid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= STATE_FRESH;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (accept) begin
                state_reg <= state_next;
            end
        end
    end

    // hold the result until the transaction completes
    always_ff @(posedge aclk) begin
        if (accept && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_result_kind    = out_reg.result_kind;
    assign m_address_byte   = out_reg.address_byte;
    assign m_address_index  = out_reg.address_index;
    assign m_status         = out_reg.status;
    assign m_command        = out_reg.command;
    assign m_address_type   = out_reg.address_type;
    assign m_port           = out_reg.port;
    assign m_address_length = out_reg.address_length;
    assign m_consumed_count = out_reg.consumed_count;

endmodule
